### src/ofrp_pkg.sv
// ----------------------------------------------------------------------------
// ofrp_pkg
// shared types and constants of the object file record parser
// ----------------------------------------------------------------------------
package ofrp_pkg;

    localparam logic [15:0] HDR_CODE   = 16'hCADE;
    localparam logic [15:0] HDR_DATA   = 16'hDADA;
    localparam logic [15:0] HDR_SYMBOL = 16'hC3B7;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_SET_ADDR,
        OP_WRITE,
        OP_LABEL,
        OP_EMPTY
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] word;
        logic        last;
    } t_cmd;

endpackage

### src/object_file_record_parser.sv
// ----------------------------------------------------------------------------
// object_file_record_parser
// object file byte stream to memory word writes and label characters
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the command queue is not full. A byte gives
// at most one result; each result passes through the front decode into the
// command queue, then into the output register. The command queue of
// QUEUE_DEPTH entries lets the byte side keep running while the result side
// is stalled; when it fills, s_tready drops. Word writes and empty labels
// carry tlast low and high, label characters carry tlast high on the final
// character.
module object_file_record_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // target_address [15:0], write_value [31:16]
    output logic [1:0]  o_m_tuser,   // kind
    output logic        o_m_tlast    // last_char
);
    import ofrp_pkg::*;

    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_cmd        front_cmd;
    t_cmd        queue_cmd;
    logic [15:0] out_addr;
    logic [15:0] out_value;

    ofrp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (full)
    );

    ofrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    ofrp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_kind  (o_m_tuser),
        .o_addr  (out_addr),
        .o_value (out_value),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {out_value, out_addr};

endmodule

### src/ofrp_front.sv
// ----------------------------------------------------------------------------
// ofrp_front
// byte pairing, header decode and record sequencing; emits back-end commands
// ----------------------------------------------------------------------------
module ofrp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output ofrp_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import ofrp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ADDR,
        PH_COUNT,
        PH_WORDS,
        PH_LABEL
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_pending, n_pending;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_count, n_count;
    logic        r_symbol, n_symbol;
    logic        gen;
    t_cmd        cmd;
    logic        accept;
    logic [15:0] word;
    logic [15:0] count_dec;

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign word      = {r_held, i_byte};
    assign count_dec = r_count - 16'd1;

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_held    = r_held;
        n_count   = r_count;
        n_symbol  = r_symbol;
        gen       = 1'b0;
        cmd.op    = OP_SET_ADDR;
        cmd.word  = word;
        cmd.last  = 1'b0;
        if (r_phase == PH_LABEL) begin
            n_count  = count_dec;
            gen      = 1'b1;
            cmd.op   = OP_LABEL;
            cmd.word = {8'd0, i_byte};
            cmd.last = (count_dec == 16'd0);
            if (count_dec == 16'd0) begin
                n_phase = PH_HEADER;
            end
        end else if (!r_pending) begin
            n_held    = i_byte;
            n_pending = 1'b1;
        end else begin
            n_pending = 1'b0;
            case (r_phase)
                PH_HEADER: begin
                    if (word == HDR_CODE || word == HDR_DATA) begin
                        n_symbol = 1'b0;
                        n_phase  = PH_ADDR;
                    end else if (word == HDR_SYMBOL) begin
                        n_symbol = 1'b1;
                        n_phase  = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    gen     = 1'b1;
                    cmd.op  = OP_SET_ADDR;
                    n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    n_count = word;
                    if (r_symbol) begin
                        if (word == 16'd0) begin
                            gen      = 1'b1;
                            cmd.op   = OP_EMPTY;
                            cmd.word = 16'd0;
                            cmd.last = 1'b1;
                            n_phase  = PH_HEADER;
                        end else begin
                            n_phase = PH_LABEL;
                        end
                    end else begin
                        n_phase = (word == 16'd0) ? PH_HEADER : PH_WORDS;
                    end
                end
                PH_WORDS: begin
                    gen     = 1'b1;
                    cmd.op  = OP_WRITE;
                    n_count = count_dec;
                    if (count_dec == 16'd0) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    assign o_push = accept && gen;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_pending <= 1'b0;
            r_held    <= 8'd0;
            r_count   <= 16'd0;
            r_symbol  <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_held    <= n_held;
            r_count   <= n_count;
            r_symbol  <= n_symbol;
        end
    end

    label_unpaired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LABEL) |-> (!r_pending && r_symbol && r_count != 16'd0))
        else $error("label phase entered with bad pairing or count state");

endmodule

### src/ofrp_queue.sv
// ----------------------------------------------------------------------------
// ofrp_queue
// small command fifo between the front and back parts
// ----------------------------------------------------------------------------
module ofrp_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ofrp_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ofrp_pkg::t_cmd o_cmd
);
    import ofrp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

### src/ofrp_back.sv
// ----------------------------------------------------------------------------
// ofrp_back
// section address tracking and registered result output
// ----------------------------------------------------------------------------
module ofrp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ofrp_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_kind,
    output logic [15:0]    o_addr,
    output logic [15:0]    o_value,
    output logic           o_last
);
    import ofrp_pkg::*;

    logic        r_valid, n_valid;
    logic [15:0] r_addr, n_addr;
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_out_addr, n_out_addr;
    logic [15:0] r_value, n_value;
    logic        r_last, n_last;

    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_comb begin
        n_valid    = r_valid && !i_ready;
        n_addr     = r_addr;
        n_kind     = r_kind;
        n_out_addr = r_out_addr;
        n_value    = r_value;
        n_last     = r_last;
        if (o_pop) begin
            n_out_addr = r_addr;
            n_value    = i_cmd.word;
            n_last     = i_cmd.last;
            case (i_cmd.op)
                OP_SET_ADDR: begin
                    n_addr = i_cmd.word;
                end
                OP_WRITE: begin
                    n_valid = 1'b1;
                    n_kind  = KIND_WRITE;
                    n_last  = 1'b0;
                    n_addr  = r_addr + 16'd1;
                end
                OP_LABEL: begin
                    n_valid = 1'b1;
                    n_kind  = KIND_CHAR;
                end
                OP_EMPTY: begin
                    n_valid = 1'b1;
                    n_kind  = KIND_EMPTY;
                    n_value = 16'd0;
                    n_last  = 1'b1;
                end
                default: begin
                    n_addr = r_addr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_addr  <= 16'd0;
        end else begin
            r_valid <= n_valid;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_out_addr <= n_out_addr;
        r_value    <= n_value;
        r_last     <= n_last;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_addr  = r_out_addr;
    assign o_value = r_value;
    assign o_last  = r_last;

    write_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.op == OP_WRITE) |=> (r_addr == $past(r_addr) + 16'd1))
        else $error("address did not advance after word write");

endmodule
